// ----- design/nssa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nssa_pkg
// Types and constants shared by the nearest-scale span addresser.
// ----------------------------------------------------------------------------
package nssa_pkg;

	localparam int SPAN_W   = 16;  // span_x, span_y, origin_x, origin_y
	localparam int LEN_IN_W = 7;   // span_length
	localparam int CROP_W   = 12;
	localparam int SIZE_W   = 13;  // dest_w, dest_h, src_w, src_h
	localparam int COORD_W  = 12;  // source_col, source_row
	localparam int IDX_W    = 3;
	localparam int WDATA_W  = 16;

	localparam int OPA_W     = SIZE_W + 1;        // pos + crop
	localparam int PROD_W    = OPA_W + SIZE_W;    // (pos + crop) * ssize
	localparam int DIV_STEPS = PROD_W - OPA_W;    // quotient bits below the range check
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_CROP_X   = 3'd2;
	localparam logic [IDX_W-1:0] REG_CROP_Y   = 3'd3;
	localparam logic [IDX_W-1:0] REG_DEST_W   = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEST_H   = 3'd5;
	localparam logic [IDX_W-1:0] REG_SRC_W    = 3'd6;
	localparam logic [IDX_W-1:0] REG_SRC_H    = 3'd7;

	typedef struct packed {
		logic signed [SPAN_W-1:0] origin_x;
		logic signed [SPAN_W-1:0] origin_y;
		logic [CROP_W-1:0]        crop_x;
		logic [CROP_W-1:0]        crop_y;
		logic [SIZE_W-1:0]        dest_w;
		logic [SIZE_W-1:0]        dest_h;
		logic [SIZE_W-1:0]        src_w;
		logic [SIZE_W-1:0]        src_h;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [SIZE_W-1:0] pos;
		logic [CROP_W-1:0] crop;
		logic [SIZE_W-1:0] ssize;
		logic [SIZE_W-1:0] dsize;
	} map_req_t;

	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] coord;
	} map_rsp_t;

	typedef enum logic [2:0] {
		MAP_IDLE,
		MAP_MUL,
		MAP_INIT,
		MAP_STEP,
		MAP_DONE
	} map_state_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_ROW,
		SEQ_ROW_WAIT,
		SEQ_PIX,
		SEQ_COL_WAIT,
		SEQ_EMIT
	} seq_state_t;

endpackage
`default_nettype wire

// ----- design/nssa_span_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nssa_span_if
// Span request channel: valid/ready with destination x, y and length.
// ----------------------------------------------------------------------------
interface nssa_span_if;
	logic                                valid;
	logic                                ready;
	logic signed [nssa_pkg::SPAN_W-1:0]  span_x;
	logic signed [nssa_pkg::SPAN_W-1:0]  span_y;
	logic [nssa_pkg::LEN_IN_W-1:0]       span_length;

	modport source (output valid, span_x, span_y, span_length, input ready);
	modport sink   (input valid, span_x, span_y, span_length, output ready);
endinterface
`default_nettype wire

// ----- design/nssa_pix_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nssa_pix_if
// Per-pixel result channel: valid/ready with source coordinates and flags.
// ----------------------------------------------------------------------------
interface nssa_pix_if;
	logic                           valid;
	logic                           ready;
	logic [nssa_pkg::COORD_W-1:0]   source_col;
	logic [nssa_pkg::COORD_W-1:0]   source_row;
	logic                           inside_res;
	logic                           last;

	modport source (output valid, source_col, source_row, inside_res, last, input ready);
	modport sink   (input valid, source_col, source_row, inside_res, last, output ready);
endinterface
`default_nettype wire

// ----- design/nearest_scale_span_addresser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_scale_span_addresser
// Nearest-neighbor scaler span addresser: one source coordinate per pixel.
// ----------------------------------------------------------------------------
// A span request is taken only while the block is idle; it then produces
// span_length result words (saturated to MAX_SPAN, none for a zero length),
// one per destination pixel, with last set on the final one. All mapping runs
// through one shared multiply/divide unit: each mapped coordinate goes through
// a multiply, a range check, 13 restoring-division steps and a result state.
// Pixels outside the scaled image skip the unit, and the source row is mapped
// once per span, only when the span's row lies inside the image.
// The final result word sits in an output register, so the next request can
// be accepted while it waits to be taken.
// ----------------------------------------------------------------------------
module nearest_scale_span_addresser #(
	parameter int MAX_SPAN   = 64,
	parameter int COORD_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	nssa_span_if.sink                          span,
	nssa_pix_if.source                         pix,
	input  wire logic                          wr_en,
	input  wire logic [nssa_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [nssa_pkg::WDATA_W-1:0]  wr_data
);

	localparam int LEN_W = $clog2(MAX_SPAN + 1);
	localparam int SW    = nssa_pkg::SPAN_W;
	localparam int ZW    = nssa_pkg::SIZE_W;
	localparam int CW    = nssa_pkg::COORD_W;

	nssa_pkg::cfg_t     cfg;
	nssa_pkg::map_req_t req;
	nssa_pkg::map_rsp_t rsp;

	nssa_pkg::seq_state_t state_q, state_d;

	logic [SW:0]       x_q;        // span_x - origin_x
	logic [ZW-1:0]     row_pos_q;
	logic              row_in_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  k_q;
	logic [CW-1:0]     srow_q;
	logic [CW-1:0]     cur_col_q;
	logic              cur_in_q;

	logic              out_valid_q;
	logic [CW-1:0]     out_col_q;
	logic [CW-1:0]     out_row_q;
	logic              out_in_q;
	logic              out_last_q;

	logic [SW:0]       row;
	logic              row_in;
	logic [LEN_W-1:0]  len_sat;
	logic [SW+1:0]     col;
	logic              col_in;
	logic              accept;
	logic              slot_free;
	logic              is_last;
	logic              load_out;

	nssa_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	nssa_map_unit #(
		.COORD_BITS (COORD_BITS)
	) u_map (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always_comb begin
		row     = {span.span_y[SW-1], span.span_y} - {cfg.origin_y[SW-1], cfg.origin_y};
		row_in  = !row[SW] && (row < (SW+1)'(cfg.dest_h));
		len_sat = (span.span_length > nssa_pkg::LEN_IN_W'(MAX_SPAN)) ?
		          LEN_W'(MAX_SPAN) : LEN_W'(span.span_length);
		col     = {x_q[SW], x_q} + (SW+2)'(k_q);
		col_in  = row_in_q && !col[SW+1] && (col < (SW+2)'(cfg.dest_w));
		accept  = span.valid && span.ready;
		slot_free = !out_valid_q || pix.ready;
		is_last   = k_q == len_q - LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nssa_pkg::SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		span.ready = 1'b0;
		load_out   = 1'b0;
		req.start  = 1'b0;
		req.pos    = col[ZW-1:0];
		req.crop   = cfg.crop_x;
		req.ssize  = cfg.src_w;
		req.dsize  = cfg.dest_w;
		case (state_q)
			nssa_pkg::SEQ_IDLE: begin
				span.ready = 1'b1;
				if (span.valid) begin
					if (len_sat == '0) state_d = nssa_pkg::SEQ_IDLE;
					else if (row_in)   state_d = nssa_pkg::SEQ_ROW;
					else               state_d = nssa_pkg::SEQ_PIX;
				end
			end
			nssa_pkg::SEQ_ROW: begin
				req.start = 1'b1;
				req.pos   = row_pos_q;
				req.crop  = cfg.crop_y;
				req.ssize = cfg.src_h;
				req.dsize = cfg.dest_h;
				state_d   = nssa_pkg::SEQ_ROW_WAIT;
			end
			nssa_pkg::SEQ_ROW_WAIT: begin
				if (rsp.done) state_d = nssa_pkg::SEQ_PIX;
			end
			nssa_pkg::SEQ_PIX: begin
				if (col_in) begin
					req.start = 1'b1;
					state_d   = nssa_pkg::SEQ_COL_WAIT;
				end else begin
					state_d = nssa_pkg::SEQ_EMIT;
				end
			end
			nssa_pkg::SEQ_COL_WAIT: begin
				if (rsp.done) state_d = nssa_pkg::SEQ_EMIT;
			end
			nssa_pkg::SEQ_EMIT: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = is_last ? nssa_pkg::SEQ_IDLE : nssa_pkg::SEQ_PIX;
				end
			end
			default: state_d = nssa_pkg::SEQ_IDLE;
		endcase
	end

	// span context and per-pixel working values
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q       <= {span.span_x[SW-1], span.span_x} - {cfg.origin_x[SW-1], cfg.origin_x};
			row_pos_q <= row[ZW-1:0];
			row_in_q  <= row_in;
			len_q     <= len_sat;
			k_q       <= '0;
		end
		if (state_q == nssa_pkg::SEQ_ROW_WAIT && rsp.done) begin
			srow_q <= rsp.coord;
		end
		if (state_q == nssa_pkg::SEQ_PIX && !col_in) begin
			cur_col_q <= '0;
			cur_in_q  <= 1'b0;
		end
		if (state_q == nssa_pkg::SEQ_COL_WAIT && rsp.done) begin
			cur_col_q <= rsp.coord;
			cur_in_q  <= 1'b1;
		end
		if (load_out) begin
			k_q        <= k_q + LEN_W'(1);
			out_col_q  <= cur_col_q;
			out_row_q  <= cur_in_q ? srow_q : '0;
			out_in_q   <= cur_in_q;
			out_last_q <= is_last;
		end
	end

	// hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign pix.valid      = out_valid_q;
	assign pix.source_col = out_col_q;
	assign pix.source_row = out_row_q;
	assign pix.inside_res = out_in_q;
	assign pix.last       = out_last_q;

endmodule
`default_nettype wire

// ----- design/nssa_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nssa_cfg_regs
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module nssa_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [nssa_pkg::IDX_W-1:0]    wr_index,
	input  wire logic [nssa_pkg::WDATA_W-1:0]  wr_data,
	output nssa_pkg::cfg_t                     cfg
);

	nssa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x <= '0;
			cfg_q.origin_y <= '0;
			cfg_q.crop_x   <= '0;
			cfg_q.crop_y   <= '0;
			cfg_q.dest_w   <= nssa_pkg::SIZE_W'(1);
			cfg_q.dest_h   <= nssa_pkg::SIZE_W'(1);
			cfg_q.src_w    <= nssa_pkg::SIZE_W'(1);
			cfg_q.src_h    <= nssa_pkg::SIZE_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				nssa_pkg::REG_ORIGIN_X: cfg_q.origin_x <= $signed(wr_data);
				nssa_pkg::REG_ORIGIN_Y: cfg_q.origin_y <= $signed(wr_data);
				nssa_pkg::REG_CROP_X:   cfg_q.crop_x   <= wr_data[nssa_pkg::CROP_W-1:0];
				nssa_pkg::REG_CROP_Y:   cfg_q.crop_y   <= wr_data[nssa_pkg::CROP_W-1:0];
				nssa_pkg::REG_DEST_W:   cfg_q.dest_w   <= wr_data[nssa_pkg::SIZE_W-1:0];
				nssa_pkg::REG_DEST_H:   cfg_q.dest_h   <= wr_data[nssa_pkg::SIZE_W-1:0];
				nssa_pkg::REG_SRC_W:    cfg_q.src_w    <= wr_data[nssa_pkg::SIZE_W-1:0];
				nssa_pkg::REG_SRC_H:    cfg_q.src_h    <= wr_data[nssa_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ----- design/nssa_map_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// nssa_map_unit
// Shared coordinate mapper: ((pos + crop) * ssize) / dsize, clamped to the
// source edge. One multiply, a range check, then restoring division steps.
// ----------------------------------------------------------------------------
module nssa_map_unit #(
	parameter int COORD_BITS = 12
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  nssa_pkg::map_req_t  req,
	output nssa_pkg::map_rsp_t  rsp
);

	localparam int SW = nssa_pkg::SIZE_W;
	localparam int CW = nssa_pkg::COORD_W;
	localparam int LIM_W = 17;
	localparam logic [LIM_W-1:0] CMAX = LIM_W'((1 << COORD_BITS) - 1);

	nssa_pkg::map_state_t state_q, state_d;

	logic [nssa_pkg::STEP_W-1:0] step_q;
	logic [nssa_pkg::OPA_W-1:0]  opa_q;
	logic [SW-1:0]               ssize_q;
	logic [SW-1:0]               dsize_q;
	logic [nssa_pkg::PROD_W-1:0] prod_q;
	logic [SW-1:0]               rem_q;
	logic [SW-1:0]               quo_q;
	logic                        ovf_q;

	logic [SW:0]   hi;
	logic [SW:0]   trial;
	logic [SW:0]   diff;
	logic          fits;
	logic [SW-1:0] lim;
	logic [SW-1:0] v_edge;
	logic [SW-1:0] v_cmax;
	logic          last_step;

	always_comb begin
		hi    = prod_q[nssa_pkg::PROD_W-1:nssa_pkg::DIV_STEPS];
		trial = {rem_q, quo_q[SW-1]};
		diff  = trial - {1'b0, dsize_q};
		fits  = trial >= {1'b0, dsize_q};
		lim   = ssize_q - SW'(1);
		// clamp to the source edge, then to the coordinate range
		v_edge = (ovf_q || (quo_q > lim)) ? lim : quo_q;
		v_cmax = ({{(LIM_W-SW){1'b0}}, v_edge} > CMAX) ? CMAX[SW-1:0] : v_edge;
		last_step = step_q == nssa_pkg::STEP_W'(nssa_pkg::DIV_STEPS - 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nssa_pkg::MAP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		rsp.done = 1'b0;
		case (state_q)
			nssa_pkg::MAP_IDLE: begin
				if (req.start) state_d = nssa_pkg::MAP_MUL;
			end
			nssa_pkg::MAP_MUL:  state_d = nssa_pkg::MAP_INIT;
			nssa_pkg::MAP_INIT: state_d = nssa_pkg::MAP_STEP;
			nssa_pkg::MAP_STEP: begin
				if (last_step) state_d = nssa_pkg::MAP_DONE;
			end
			nssa_pkg::MAP_DONE: begin
				rsp.done = 1'b1;
				state_d  = nssa_pkg::MAP_IDLE;
			end
			default: state_d = nssa_pkg::MAP_IDLE;
		endcase
	end

	assign rsp.coord = (ssize_q == '0) ? '0 : v_cmax[CW-1:0];

	always_ff @(posedge clk) begin
		case (state_q)
			nssa_pkg::MAP_IDLE: begin
				opa_q   <= nssa_pkg::OPA_W'(req.pos) + nssa_pkg::OPA_W'(req.crop);
				ssize_q <= req.ssize;
				dsize_q <= req.dsize;
			end
			nssa_pkg::MAP_MUL: begin
				prod_q <= nssa_pkg::PROD_W'(opa_q) * nssa_pkg::PROD_W'(ssize_q);
			end
			nssa_pkg::MAP_INIT: begin
				// a quotient past the low bits is beyond every source edge
				ovf_q  <= hi >= {1'b0, dsize_q};
				rem_q  <= hi[SW-1:0];
				quo_q  <= prod_q[nssa_pkg::DIV_STEPS-1:0];
				step_q <= '0;
			end
			nssa_pkg::MAP_STEP: begin
				rem_q  <= fits ? diff[SW-1:0] : trial[SW-1:0];
				quo_q  <= {quo_q[SW-2:0], fits};
				step_q <= step_q + nssa_pkg::STEP_W'(1);
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- tb/sv/tb_nearest_scale_span_addresser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_nearest_scale_span_addresser
// Self-checking bench for the span addresser. Span requests go in from a
// queue, and a local scaler model expands each accepted span into the pixel
// words it should produce. Every pixel word taken from the block is checked
// against the oldest of these. Directed spans hit the image edges, clamping,
// zero sizes, zero and oversized lengths. Random spans then follow across
// several scale settings, with the sender and receiver stalling at varied rates.
// ----------------------------------------------------------------------------
module tb_nearest_scale_span_addresser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_SPAN      = 64;
	localparam int COORD_BITS    = 12;
	localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
	localparam int SETTLE_CYCLES = 32;
	localparam int CYCLE_LIMIT   = 3_000_000;

	typedef struct packed {
		logic signed [nssa_pkg::SPAN_W-1:0] x;
		logic signed [nssa_pkg::SPAN_W-1:0] y;
		logic [nssa_pkg::LEN_IN_W-1:0]      len;
	} span_req_t;

	typedef struct packed {
		logic [nssa_pkg::COORD_W-1:0] col;
		logic [nssa_pkg::COORD_W-1:0] row;
		logic                         in_img;
		logic                         last;
	} pix_word_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         wr_en;
	logic [nssa_pkg::IDX_W-1:0]   wr_index;
	logic [nssa_pkg::WDATA_W-1:0] wr_data;

	nssa_span_if span_bus ();
	nssa_pix_if  pix_bus ();

	nssa_pkg::cfg_t scale_cfg;
	span_req_t      pending_spans[$];
	pix_word_t      expected_pix[$];
	span_req_t      next_span;
	pix_word_t      got_pix;
	pix_word_t      want_pix;
	bit             span_took;
	int unsigned    send_idle_pct;
	int unsigned    recv_idle_pct;
	int             fail_count;
	int             cycle_count;

	nearest_scale_span_addresser #(
		.MAX_SPAN   (MAX_SPAN),
		.COORD_BITS (COORD_BITS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.span     (span_bus),
		.pix      (pix_bus),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic logic [nssa_pkg::COORD_W-1:0] nearest_coord(int unsigned pos,
			int unsigned crop, int unsigned ssize, int unsigned dsize);
		longint unsigned q;
		if (ssize == 0) begin
			return '0;
		end
		q = (longint'(pos) + crop) * ssize / dsize;
		if (q > ssize - 1)
			q = ssize - 1;
		if (q > COORD_MAX)
			q = COORD_MAX;
		return q[nssa_pkg::COORD_W-1:0];
	endfunction

	function automatic void expand_span(span_req_t req);
		int                           col0;
		int                           row;
		int                           col;
		int                           n;
		bit                           row_in;
		bit                           hit;
		logic [nssa_pkg::COORD_W-1:0] srow;
		pix_word_t                    w;
		col0   = int'($signed(req.x)) - int'($signed(scale_cfg.origin_x));
		row    = int'($signed(req.y)) - int'($signed(scale_cfg.origin_y));
		n      = (req.len > MAX_SPAN) ? MAX_SPAN : int'(req.len);
		row_in = (row >= 0) && (row < int'(scale_cfg.dest_h));
		srow   = row_in ? nearest_coord(row, scale_cfg.crop_y, scale_cfg.src_h, scale_cfg.dest_h)
		                : '0;
		for (int k = 0; k < n; k++) begin
			col      = col0 + k;
			hit      = row_in && (col >= 0) && (col < int'(scale_cfg.dest_w));
			w.col    = hit ? nearest_coord(col, scale_cfg.crop_x, scale_cfg.src_w,
			                               scale_cfg.dest_w) : '0;
			w.row    = hit ? srow : '0;
			w.in_img = hit;
			w.last   = (k == n - 1);
			expected_pix.push_back(w);
		end
	endfunction

	// Sender side: hold the word until taken, then advance or idle.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!span_bus.valid || span_took) begin
				if (pending_spans.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_span = pending_spans.pop_front();
					span_bus.valid       <= 1'b1;
					span_bus.span_x      <= next_span.x;
					span_bus.span_y      <= next_span.y;
					span_bus.span_length <= next_span.len;
				end else begin
					span_bus.valid <= 1'b0;
				end
			end
		end
		pix_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		span_took = arst_n && span_bus.valid && span_bus.ready;
		if (span_took) begin
			expand_span('{x: span_bus.span_x, y: span_bus.span_y, len: span_bus.span_length});
		end
		if (arst_n && pix_bus.valid && pix_bus.ready) begin
			got_pix = '{col: pix_bus.source_col, row: pix_bus.source_row,
			            in_img: pix_bus.inside_res, last: pix_bus.last};
			if (expected_pix.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected pixel word col=%0d row=%0d inside=%0b last=%0b",
				         $time, got_pix.col, got_pix.row, got_pix.in_img, got_pix.last);
			end else begin
				want_pix = expected_pix.pop_front();
				if (got_pix.col !== want_pix.col || got_pix.row !== want_pix.row ||
				    got_pix.in_img !== want_pix.in_img || got_pix.last !== want_pix.last) begin
					fail_count++;
					$display("%0t: pixel word mismatch: expected col=%0d row=%0d inside=%0b",
					         $time, want_pix.col, want_pix.row, want_pix.in_img,
					         " last=%0b, got col=%0d row=%0d inside=%0b last=%0b",
					         want_pix.last, got_pix.col, got_pix.row, got_pix.in_img,
					         got_pix.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic write_reg(input logic [nssa_pkg::IDX_W-1:0] idx, input int unsigned value);
		logic [nssa_pkg::WDATA_W-1:0] data;
		data = value[nssa_pkg::WDATA_W-1:0];
		// unused upper bits get noise; the register must drop them
		case (idx)
			nssa_pkg::REG_CROP_X, nssa_pkg::REG_CROP_Y: begin
				data[nssa_pkg::WDATA_W-1:nssa_pkg::CROP_W] =
					(nssa_pkg::WDATA_W-nssa_pkg::CROP_W)'($urandom());
			end
			nssa_pkg::REG_DEST_W, nssa_pkg::REG_DEST_H,
			nssa_pkg::REG_SRC_W, nssa_pkg::REG_SRC_H: begin
				data[nssa_pkg::WDATA_W-1:nssa_pkg::SIZE_W] =
					(nssa_pkg::WDATA_W-nssa_pkg::SIZE_W)'($urandom());
			end
			default: ;
		endcase
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
		wr_en    <= 1'b0;
		case (idx)
			nssa_pkg::REG_ORIGIN_X: scale_cfg.origin_x = data;
			nssa_pkg::REG_ORIGIN_Y: scale_cfg.origin_y = data;
			nssa_pkg::REG_CROP_X:   scale_cfg.crop_x   = data[nssa_pkg::CROP_W-1:0];
			nssa_pkg::REG_CROP_Y:   scale_cfg.crop_y   = data[nssa_pkg::CROP_W-1:0];
			nssa_pkg::REG_DEST_W:   scale_cfg.dest_w   = data[nssa_pkg::SIZE_W-1:0];
			nssa_pkg::REG_DEST_H:   scale_cfg.dest_h   = data[nssa_pkg::SIZE_W-1:0];
			nssa_pkg::REG_SRC_W:    scale_cfg.src_w    = data[nssa_pkg::SIZE_W-1:0];
			nssa_pkg::REG_SRC_H:    scale_cfg.src_h    = data[nssa_pkg::SIZE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input int ox, input int oy, input int cx, input int cy,
			input int dw, input int dh, input int sw, input int sh);
		write_reg(nssa_pkg::REG_ORIGIN_X, ox);
		write_reg(nssa_pkg::REG_ORIGIN_Y, oy);
		write_reg(nssa_pkg::REG_CROP_X, cx);
		write_reg(nssa_pkg::REG_CROP_Y, cy);
		write_reg(nssa_pkg::REG_DEST_W, dw);
		write_reg(nssa_pkg::REG_DEST_H, dh);
		write_reg(nssa_pkg::REG_SRC_W, sw);
		write_reg(nssa_pkg::REG_SRC_H, sh);
	endtask

	function automatic void add_span(int x, int y, int len);
		pending_spans.push_back('{x: x[nssa_pkg::SPAN_W-1:0], y: y[nssa_pkg::SPAN_W-1:0],
		                          len: len[nssa_pkg::LEN_IN_W-1:0]});
	endfunction

	task automatic wait_drained();
		@(posedge clk);
		while (pending_spans.size() != 0 || span_bus.valid || expected_pix.size() != 0)
			@(posedge clk);
		// a zero-length span may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		int unsigned style;
		int          dw, dh, sw, sh, cx, cy;
		style = $urandom_range(3);
		case (style)
			0: begin
				dw = $urandom_range(1, 48);
				dh = $urandom_range(1, 48);
				sw = $urandom_range(1, 48);
				sh = $urandom_range(1, 48);
				cx = $urandom_range(0, 15);
				cy = $urandom_range(0, 15);
			end
			1: begin
				dw = $urandom_range(1, 4096);
				dh = $urandom_range(1, 4096);
				sw = $urandom_range(1, 4096);
				sh = $urandom_range(1, 4096);
				cx = $urandom_range(0, 4095);
				cy = $urandom_range(0, 4095);
			end
			2: begin
				dw = $urandom_range(1) ? 4096 : 1;
				dh = $urandom_range(1) ? 4096 : 1;
				sw = $urandom_range(1) ? 4096 : 1;
				sh = $urandom_range(1) ? 4096 : 1;
				cx = $urandom_range(1) ? 4095 : 0;
				cy = $urandom_range(1) ? 4095 : 0;
			end
			default: begin
				// strong downscale
				dw = $urandom_range(1, 32);
				dh = $urandom_range(1, 32);
				sw = $urandom_range(1024, 4096);
				sh = $urandom_range(1024, 4096);
				cx = $urandom_range(0, 4095);
				cy = $urandom_range(0, 4095);
			end
		endcase
		load_config($urandom_range(65535), $urandom_range(65535), cx, cy, dw, dh, sw, sh);
	endtask

	task automatic random_spans(input int count);
		int unsigned pick;
		int          x, y, len, ox, oy;
		ox = int'($signed(scale_cfg.origin_x));
		oy = int'($signed(scale_cfg.origin_y));
		repeat (count) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				// aim at the scaled image, crossing its edges now and then
				x = ox + int'($urandom_range(0, int'(scale_cfg.dest_w) + 40)) - 36;
				y = oy + int'($urandom_range(0, int'(scale_cfg.dest_h) + 1)) - 1;
			end else begin
				x = $urandom();
				y = $urandom();
			end
			pick = $urandom_range(99);
			if (pick < 60)
				len = $urandom_range(1, 8);
			else if (pick < 82)
				len = $urandom_range(9, 40);
			else if (pick < 94)
				len = $urandom_range(41, 64);
			else
				len = $urandom_range(0, 127);
			add_span(x, y, len);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		wr_en                = 1'b0;
		wr_index             = '0;
		wr_data              = '0;
		span_bus.valid       = 1'b0;
		span_bus.span_x      = '0;
		span_bus.span_y      = '0;
		span_bus.span_length = '0;
		pix_bus.ready        = 1'b0;
		span_took            = 1'b0;
		fail_count           = 0;
		cycle_count          = 0;
		send_idle_pct        = 26;
		recv_idle_pct        = 76;
		scale_cfg = '{origin_x: '0, origin_y: '0, crop_x: '0, crop_y: '0,
		              dest_w: 1, dest_h: 1, src_w: 1, src_h: 1};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset sizes: a one-pixel image
		add_span(0, 0, 1);
		add_span(-1, 0, 3);
		add_span(0, 1, 2);
		add_span(0, 0, 0);
		add_span(0, 0, 127);
		add_span(0, 0, 64);
		wait_drained();

		// largest sizes with full crop: coordinates clamp at the source edge
		load_config(100, -32768, 4095, 4095, 4096, 4096, 4096, 4096);
		add_span(100, -32768, 4);
		add_span(32767, 32767, 2);
		add_span(-32768, -28673, 2);
		add_span(4194, -28673, 3);
		wait_drained();

		// zero destination sizes: nothing is inside
		write_reg(nssa_pkg::REG_ORIGIN_X, 0);
		write_reg(nssa_pkg::REG_ORIGIN_Y, 0);
		write_reg(nssa_pkg::REG_DEST_W, 0);
		write_reg(nssa_pkg::REG_DEST_H, 0);
		add_span(0, 0, 5);
		add_span(-5, 0, 10);
		wait_drained();
		write_reg(nssa_pkg::REG_DEST_H, 4);
		add_span(0, 1, 3);
		wait_drained();

		// zero source sizes, then a small upscale
		load_config(32767, -1, 0, 0, 8, 8, 0, 0);
		add_span(32767, -1, 9);
		add_span(-32768, 6, 2);
		wait_drained();
		write_reg(nssa_pkg::REG_SRC_W, 3);
		write_reg(nssa_pkg::REG_SRC_H, 5);
		add_span(32767, -1, 8);
		add_span(32767, 6, 8);
		wait_drained();

		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 26 : (mode == 1) ? 76 : 0;
			recv_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 26 : 0;
			repeat (2) begin
				random_config();
				random_spans(32);
				wait_drained();
			end
		end

		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
